// ===== rtl/stb_pkg.sv =====
package stb_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_RESET = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_TICK  = 3'd4,
        OP_CLEAR = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    localparam logic [23:0] STEP_RESET = 24'd500000;
    localparam logic [9:0]  US_PER_MS  = 10'd1000;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] timer_id;
        logic [21:0] delay_ms;
        logic        periodic;
        logic        start_active;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] event_id;
        logic        status;
        logic        last;
    } t_out;

endpackage

// ===== rtl/software_timer_bank.sv =====
// Bank of TIMERS countdown timers driven by single-cycle commands. A command is
// taken when start is high and busy is low; each result appears on o_result
// for one cycle with o_valid high and cannot be held off. Add, reset, start,
// stop and clear produce one acknowledge. An add to a full table is refused
// with status set and does not raise busy; any other add keeps busy high through
// a registered delay_ms*1000 multiply, then the entry write, which registers its
// acknowledge. Reset/start/stop walk the table through one shared id compare,
// and a tick walks it through one shared subtract/compare unit, emitting one
// expiry per expired entry and then a done result. A walk spends a read step
// and a process step on every entry, then a closing step registers the last result.
// Timer state sits in a single-port memory read at the walk address and written
// at most once per walk step.
module software_timer_bank #(
    parameter int TIMERS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  stb_pkg::t_in   i_cmd,
    input  logic           i_cfg_we,
    input  logic [23:0]    i_cfg_data,
    output logic           o_valid,
    output stb_pkg::t_out  o_result
);
    import stb_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    typedef struct packed {
        logic [15:0] ident;
        logic        running;
        logic        repeat_en;
        logic [31:0] reload_us;
        logic [31:0] remaining_us;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_WRITE, ST_READ, ST_PROC, ST_ACK
    } t_state;

    t_entry      r_mem [TIMERS];
    t_entry      r_rd;
    t_state      r_state;
    t_in         r_cmd;
    logic [23:0] r_step;
    logic [15:0] r_next_id;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_idx;
    logic        r_found;
    logic [31:0] r_prod;
    logic        r_valid;
    t_out        r_res;

    logic [IW-1:0] w_addr;
    logic          w_we;
    t_entry        w_wdata;
    logic          w_in_table;

    assign w_addr     = r_idx[IW-1:0];
    assign w_in_table = r_idx < r_total;
    assign busy       = r_state != ST_IDLE;
    assign o_valid    = r_valid;
    assign o_result   = r_res;

    // write path for an added entry and for the entry under the walk
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_rd;
        if (r_state == ST_WRITE) begin
            w_we                 = 1'b1;
            w_wdata.ident        = r_next_id;
            w_wdata.running      = r_cmd.start_active;
            w_wdata.repeat_en    = r_cmd.periodic;
            w_wdata.reload_us    = r_prod;
            w_wdata.remaining_us = r_prod;
        end else if (r_state == ST_PROC && w_in_table) begin
            if (r_cmd.op == OP_TICK) begin
                if (r_rd.running) begin
                    w_we = 1'b1;
                    if (r_rd.remaining_us < {8'd0, r_step}) begin
                        if (r_rd.repeat_en) begin
                            w_wdata.remaining_us = r_rd.reload_us;
                        end else begin
                            w_wdata.remaining_us = '0;
                            w_wdata.running      = 1'b0;
                        end
                    end else begin
                        w_wdata.remaining_us = r_rd.remaining_us - {8'd0, r_step};
                    end
                end
            end else if (!r_found && r_rd.ident == r_cmd.timer_id) begin
                w_we = 1'b1;
                if (r_cmd.op == OP_RESET) w_wdata.remaining_us = r_rd.reload_us;
                else w_wdata.running = (r_cmd.op == OP_START);
            end
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rd <= r_mem[w_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= STEP_RESET;
            r_next_id <= 16'd1;
            r_total   <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) r_step <= i_cfg_data;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        case (i_cmd.op)
                            OP_ADD: begin
                                if (r_total >= CW'(TIMERS)) begin
                                    r_valid <= 1'b1;
                                    r_res   <= '{KIND_ACK, 16'd0, 1'b1, 1'b1};
                                end else begin
                                    r_idx   <= r_total;
                                    r_state <= ST_MUL;
                                end
                            end
                            OP_RESET, OP_START, OP_STOP, OP_TICK: r_state <= ST_READ;
                            OP_CLEAR: begin
                                r_total <= '0;
                                r_valid <= 1'b1;
                                r_res   <= '{KIND_ACK, 16'd0, 1'b0, 1'b1};
                            end
                            default: begin
                                r_valid <= 1'b1;
                                r_res   <= '{KIND_ACK, 16'd0, 1'b0, 1'b1};
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_prod  <= 32'(r_cmd.delay_ms) * 32'(US_PER_MS);
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_total   <= r_total + 1'b1;
                    r_next_id <= r_next_id + 16'd1;
                    r_valid   <= 1'b1;
                    r_res     <= '{KIND_ACK, r_next_id, 1'b0, 1'b1};
                    r_state   <= ST_IDLE;
                end
                ST_READ: r_state <= ST_PROC;
                ST_PROC: begin
                    if (w_in_table) begin
                        if (r_cmd.op == OP_TICK) begin
                            if (r_rd.running && r_rd.remaining_us < {8'd0, r_step}) begin
                                r_valid <= 1'b1;
                                r_res   <= '{KIND_EXPIRY, r_rd.ident, 1'b0, 1'b0};
                            end
                        end else if (r_rd.ident == r_cmd.timer_id) begin
                            r_found <= 1'b1;
                        end
                    end
                    if (r_idx == CW'(TIMERS - 1)) begin
                        r_state <= ST_ACK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_READ;
                    end
                end
                ST_ACK: begin
                    r_valid <= 1'b1;
                    if (r_cmd.op == OP_TICK) begin
                        r_res <= '{KIND_DONE, 16'd0, 1'b0, 1'b1};
                    end else begin
                        r_res <= '{KIND_ACK, 16'd0, 1'b0, 1'b1};
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/tb_software_timer_bank.sv =====
module tb_software_timer_bank;
    import stb_pkg::*;

    localparam int TIMERS  = 16;
    localparam int SETTLE  = 3 * (TIMERS + 2);

    // scoreboard: shadow timer table and the queue of results still to come
    class timer_scoreboard;
        logic [23:0] step_us;
        bit          used [TIMERS];
        logic [15:0] ident [TIMERS];
        bit          running [TIMERS];
        bit          repeats [TIMERS];
        logic [31:0] reload_us [TIMERS];
        logic [31:0] remain_us [TIMERS];
        logic [15:0] next_id;
        int          total;
        t_out        awaited_results[$];
        int          errors;

        function new();
            step_us = STEP_RESET;
            foreach (used[i]) begin
                used[i] = 0;
            end
            next_id = 16'd1;
            total   = 0;
            errors  = 0;
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function void push(t_kind k, logic [15:0] id, logic st, logic lst);
            t_out r;
            r.kind     = k;
            r.event_id = id;
            r.status   = st;
            r.last     = lst;
            awaited_results.push_back(r);
        endfunction

        // predict the results of one accepted transaction
        function void note_command(t_in c);
            int slot;
            slot = -1;
            case (c.op)
                OP_ADD: begin
                    if (total >= TIMERS) begin
                        push(KIND_ACK, 16'd0, 1'b1, 1'b1);
                    end else begin
                        used[total]      = 1;
                        ident[total]     = next_id;
                        running[total]   = c.start_active;
                        repeats[total]   = c.periodic;
                        reload_us[total] = 32'(c.delay_ms) * 32'd1000;
                        remain_us[total] = reload_us[total];
                        total++;
                        push(KIND_ACK, next_id, 1'b0, 1'b1);
                        next_id = next_id + 16'd1;
                    end
                end
                OP_RESET, OP_START, OP_STOP: begin
                    for (int i = 0; i < TIMERS; i++) begin
                        if (slot < 0 && used[i] && ident[i] == c.timer_id) slot = i;
                    end
                    if (slot >= 0) begin
                        if (c.op == OP_RESET) remain_us[slot] = reload_us[slot];
                        else running[slot] = (c.op == OP_START);
                    end
                    push(KIND_ACK, 16'd0, 1'b0, 1'b1);
                end
                OP_TICK: begin
                    for (int i = 0; i < TIMERS; i++) begin
                        if (used[i] && running[i]) begin
                            if (remain_us[i] < 32'(step_us)) begin
                                push(KIND_EXPIRY, ident[i], 1'b0, 1'b0);
                                if (repeats[i]) begin
                                    remain_us[i] = reload_us[i];
                                end else begin
                                    remain_us[i] = 0;
                                    running[i]   = 0;
                                end
                            end else begin
                                remain_us[i] = remain_us[i] - 32'(step_us);
                            end
                        end
                    end
                    push(KIND_DONE, 16'd0, 1'b0, 1'b1);
                end
                OP_CLEAR: begin
                    foreach (used[i]) begin
                        used[i] = 0;
                    end
                    total = 0;
                    push(KIND_ACK, 16'd0, 1'b0, 1'b1);
                end
                default: push(KIND_ACK, 16'd0, 1'b0, 1'b1);
            endcase
        endfunction

        // compare one result transaction with the oldest prediction
        task check_result(t_out r);
            t_out e;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", r));
            end else begin
                e = awaited_results.pop_front();
                if (r.kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", r.kind, e.kind));
                if (r.event_id !== e.event_id)
                    report_mismatch($sformatf("event_id %0d, want %0d", r.event_id, e.event_id));
                if (r.status !== e.status)
                    report_mismatch($sformatf("status %0b, want %0b", r.status, e.status));
                if (r.last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", r.last, e.last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_cmd = '0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic        o_valid;
    t_out        o_result;

    timer_scoreboard sb = new();
    bit              quiet = 0;

    software_timer_bank #(.TIMERS(TIMERS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    always #10 i_clk = ~i_clk;

    // watch both sides of the block
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_command(i_cmd);
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // hang guard
    initial begin
        #(20 * 400000);
        $display("Regression FAIL");
        $finish;
    end

    // one command transaction, with an occasional random idle gap ahead of it
    task send_cmd(t_in c);
        if (!quiet && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task drain();
        start <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_step(logic [23:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.step_us = v;
    endtask

    function t_in make_cmd(logic [2:0] op, logic [15:0] id, logic [21:0] d, bit p, bit a);
        t_in c;
        c.op           = op;
        c.timer_id     = id;
        c.delay_ms     = d;
        c.periodic     = p;
        c.start_active = a;
        return c;
    endfunction

    function logic [15:0] pick_id();
        if (sb.next_id > 16'd1 && $urandom_range(0, 7) != 0)
            return 16'($urandom_range(1, sb.next_id - 1));
        return 16'($urandom);
    endfunction

    // random command mix leaning on add and tick so expiries keep coming
    function t_in random_cmd();
        t_in c;
        int  w;
        logic [21:0] d;
        c = 16'($urandom) == 0 ? '0 : t_in'(43'({$urandom, $urandom}));
        w = $urandom_range(0, 99);
        d = ($urandom_range(0, 9) == 0) ? 22'($urandom) : 22'($urandom_range(0, 3000));
        if (w < 28)       c = make_cmd(OP_ADD, 16'($urandom), d, 1'($urandom), 1'($urandom));
        else if (w < 40)  c.op = OP_RESET;
        else if (w < 50)  c.op = OP_START;
        else if (w < 58)  c.op = OP_STOP;
        else if (w < 92)  c.op = OP_TICK;
        else if (w < 96)  c.op = OP_CLEAR;
        else              c.op = 3'($urandom_range(6, 7));
        if (c.op inside {OP_RESET, OP_START, OP_STOP}) c.timer_id = pick_id();
        return c;
    endfunction

    initial begin
        logic [23:0] steps [5];
        steps = '{24'd1, 24'hFFFFFF, 24'd0, STEP_RESET, 24'd0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_step(STEP_RESET);

        // directed: field extremes, every op, unknown ids, unused codes
        send_cmd(make_cmd(OP_ADD, 16'hFFFF, 22'h3FFFFF, 1'b1, 1'b1));
        send_cmd(make_cmd(OP_ADD, 16'd0, 22'd0, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_ADD, 16'd0, 22'd600, 1'b1, 1'b1));
        send_cmd(make_cmd(OP_ADD, 16'd0, 22'd1, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_TICK, 16'd0, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_TICK, 16'd0, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_START, 16'd2, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_START, 16'd4, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_TICK, 16'd0, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_STOP, 16'd3, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_RESET, 16'd1, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_RESET, 16'hFFFF, 22'h3FFFFF, 1'b1, 1'b1));
        send_cmd(make_cmd(OP_TICK, 16'd0, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(3'd6, 16'd1, 22'd5, 1'b1, 1'b1));
        send_cmd(make_cmd(3'd7, 16'd2, 22'd5, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_CLEAR, 16'd0, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_START, 16'd1, 22'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_ADD, 16'd0, 22'd300, 1'b1, 1'b1));
        send_cmd(make_cmd(OP_TICK, 16'd0, 22'd0, 1'b0, 1'b0));

        // random phases across tick steps, one phase with no idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_step(ph == 5 ? 24'($urandom_range(1, 24'hFFFFFF)) : steps[ph - 1]);
            quiet = (ph == 2);
            for (int n = 0; n < 52; n++) begin
                send_cmd(random_cmd());
                if (n == 26 && ph == 1) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (sb.awaited_results.size() != 0) @(posedge i_clk);
                end
            end
        end
        start <= 1'b0;

        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.awaited_results.size() != 0)
            sb.report_mismatch("results still awaited at end");
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stb_pkg.sv
rtl/software_timer_bank.sv
tb/tb_software_timer_bank.sv
